// ===== hw/rtl/temp_filter_slope_peak_defines.svh =====
// assertion macros for the temperature filter block
`ifndef TEMP_FILTER_SLOPE_PEAK_DEFINES_SVH
`define TEMP_FILTER_SLOPE_PEAK_DEFINES_SVH

// implication checked on every clock edge outside reset
`define TFSP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define TFSP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hw/rtl/tfsp_pkg.sv =====
// ----------------------------------------------------------------------------
// tfsp_pkg
// shared types, constants and filter helper functions of the temperature filter block
// ----------------------------------------------------------------------------
package tfsp_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int TIME_BITS   = 32;
    localparam int SHIFT_BITS  = 4;
    localparam int IVAL_BITS   = 16;
    localparam int SLOPE_SCALE = 3600;
    localparam int MAG_BITS    = SAMPLE_BITS + 1 + 12;
    localparam int CFG_IDX_BITS = 3;

    localparam logic [CFG_IDX_BITS-1:0] CFG_FAST_SHIFT  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SLOW_SHIFT  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SLOPE_SHIFT = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_VALID   = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_VALID   = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_INTERVAL    = 3'd5;

    typedef logic signed [SAMPLE_BITS-1:0] t_smp;

    typedef struct packed {
        logic                  ok;
        t_smp                  sample;
        logic [TIME_BITS-1:0]  now;
        logic                  ack_max;
        logic                  ack_min;
    } t_cmd;

    typedef struct packed {
        logic connected;
        t_smp fast_value;
        t_smp slow_value;
        t_smp slope_value;
        logic max_found;
        t_smp max_value;
        logic min_found;
        t_smp min_value;
    } t_res;

    function automatic t_smp sat17(input logic signed [SAMPLE_BITS+1:0] v);
        logic signed [SAMPLE_BITS+1:0] hi;
        logic signed [SAMPLE_BITS+1:0] lo;
        hi = (SAMPLE_BITS+2)'((1 <<< (SAMPLE_BITS-1)) - 1);
        lo = -hi - (SAMPLE_BITS+2)'(1);
        if (v > hi) return hi[SAMPLE_BITS-1:0];
        if (v < lo) return lo[SAMPLE_BITS-1:0];
        return v[SAMPLE_BITS-1:0];
    endfunction

    function automatic t_smp ema(input t_smp x, input t_smp p, input logic [SHIFT_BITS-1:0] s);
        logic signed [SAMPLE_BITS+1:0] d;
        d = {{2{x[SAMPLE_BITS-1]}}, x} - {{2{p[SAMPLE_BITS-1]}}, p};
        d = d >>> s;
        return sat17({{2{p[SAMPLE_BITS-1]}}, p} + d);
    endfunction

endpackage

// ===== hw/rtl/tfsp_front.sv =====
// ----------------------------------------------------------------------------
// tfsp_front
// accepts sample words, range checks them and pushes commands into a queue
// ----------------------------------------------------------------------------
module tfsp_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  tfsp_pkg::t_smp                i_sample,
    input  logic                          i_present,
    input  logic [tfsp_pkg::TIME_BITS-1:0] i_now,
    input  logic                          i_ack_max,
    input  logic                          i_ack_min,
    input  tfsp_pkg::t_smp                i_min_valid,
    input  tfsp_pkg::t_smp                i_max_valid,
    output logic                          o_cmd_valid,
    output tfsp_pkg::t_cmd                o_cmd,
    input  logic                          i_cmd_pop
);
    tfsp_pkg::t_cmd r_q [2];
    logic           r_wp, r_rp;
    logic [1:0]     r_cnt;
    logic           push;
    tfsp_pkg::t_cmd c;

    assign o_stall     = (r_cnt == 2'd2);
    assign push        = i_valid && !o_stall;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];

    always_comb begin
        c.ok      = i_present && (i_sample >= i_min_valid) && (i_sample <= i_max_valid);
        c.sample  = i_sample;
        c.now     = i_now;
        c.ack_max = i_ack_max;
        c.ack_min = i_ack_min;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (i_cmd_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(i_cmd_pop);
        end
        if (push) r_q[r_wp] <= c;
    end
endmodule

// ===== hw/rtl/tfsp_div.sv =====
// ----------------------------------------------------------------------------
// tfsp_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module tfsp_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [tfsp_pkg::MAG_BITS-1:0]  i_num,
    input  logic [tfsp_pkg::TIME_BITS-1:0] i_den,
    output logic                          o_done,
    output logic [tfsp_pkg::MAG_BITS-1:0]  o_quo
);
    localparam int CNT_BITS = $clog2(tfsp_pkg::MAG_BITS + 1);
    logic [tfsp_pkg::MAG_BITS-1:0]  r_quo;
    logic [tfsp_pkg::TIME_BITS:0]   r_rem;
    logic [tfsp_pkg::TIME_BITS-1:0] r_den;
    logic [CNT_BITS-1:0]            r_cnt;
    logic                           r_busy, r_done;
    logic [tfsp_pkg::TIME_BITS:0]   sh, df;

    assign sh     = {r_rem[tfsp_pkg::TIME_BITS-1:0], r_quo[tfsp_pkg::MAG_BITS-1]};
    assign df     = sh - {1'b0, r_den};
    assign o_done = r_done;
    assign o_quo  = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_BITS'(tfsp_pkg::MAG_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_BITS'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            if (!df[tfsp_pkg::TIME_BITS]) begin
                r_rem <= df;
                r_quo <= {r_quo[tfsp_pkg::MAG_BITS-2:0], 1'b1};
            end else begin
                r_rem <= sh;
                r_quo <= {r_quo[tfsp_pkg::MAG_BITS-2:0], 1'b0};
            end
        end
    end
endmodule

// ===== hw/rtl/tfsp_back.sv =====
// ----------------------------------------------------------------------------
// tfsp_back
// filter state, slope sequencer and output register
// ----------------------------------------------------------------------------
module tfsp_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cmd_valid,
    input  tfsp_pkg::t_cmd         i_cmd,
    output logic                   o_cmd_pop,
    input  logic [tfsp_pkg::SHIFT_BITS-1:0] i_fast_shift,
    input  logic [tfsp_pkg::SHIFT_BITS-1:0] i_slow_shift,
    input  logic [tfsp_pkg::SHIFT_BITS-1:0] i_slope_shift,
    input  logic [tfsp_pkg::IVAL_BITS-1:0]  i_interval,
    output logic                   o_valid,
    input  logic                   i_stall,
    output tfsp_pkg::t_res         o_res
);
    localparam int SB = tfsp_pkg::SAMPLE_BITS;
    localparam int MB = tfsp_pkg::MAG_BITS;
    localparam int TB = tfsp_pkg::TIME_BITS;

    typedef enum logic [2:0] {S_IDLE, S_MAG, S_DIV, S_FIN, S_OUT} t_st;
    t_st r_st;

    logic r_seeded, r_max_flag, r_min_flag, r_neg;
    tfsp_pkg::t_smp r_fast, r_slow, r_ref, r_prev, r_slope, r_max_hold, r_min_hold, r_x;
    tfsp_pkg::t_smp r_dref;
    logic [TB-1:0] r_last;
    logic [TB-1:0] r_elapsed;
    logic r_ok;

    tfsp_pkg::t_smp nf, ns;
    logic [TB-1:0]  elapsed;
    logic           trig;
    logic           div_go;
    logic signed [SB:0] d;
    logic [SB:0]    dmag;
    logic [MB-1:0]  mag;
    logic           dv_start, dv_done;
    logic [MB-1:0]  quo;
    logic [SB-1:0]  qsat;
    logic signed [SB+1:0] raw;

    assign o_cmd_pop = (r_st == S_IDLE) && i_cmd_valid;
    assign nf = r_seeded ? tfsp_pkg::ema(i_cmd.sample, r_fast, i_fast_shift) : i_cmd.sample;
    assign ns = r_seeded ? tfsp_pkg::ema(i_cmd.sample, r_slow, i_slow_shift) : i_cmd.sample;
    assign elapsed = i_cmd.now - r_last;
    assign trig = elapsed >= TB'(i_interval);
    assign div_go = trig && (elapsed != '0);
    assign d    = {r_slow[SB-1], r_slow} - {r_dref[SB-1], r_dref};
    assign dmag = d[SB] ? (SB+1)'(-d) : (SB+1)'(d);
    assign mag  = MB'(dmag) * MB'(tfsp_pkg::SLOPE_SCALE);
    assign dv_start = (r_st == S_MAG);
    assign qsat = (quo > MB'(1 << (SB-1))) ? SB'(1 << (SB-1)) : quo[SB-1:0];
    assign raw  = r_neg ? -(SB+2)'({2'b0, qsat}) : (SB+2)'({2'b0, qsat});

    tfsp_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(dv_start),
        .i_num(mag), .i_den(r_elapsed), .o_done(dv_done), .o_quo(quo)
    );

    assign o_valid = (r_st == S_OUT);
    always_comb begin
        o_res.connected   = r_ok;
        o_res.fast_value  = r_fast;
        o_res.slow_value  = r_slow;
        o_res.slope_value = r_slope;
        o_res.max_found   = r_max_flag;
        o_res.max_value   = r_max_hold;
        o_res.min_found   = r_min_flag;
        o_res.min_value   = r_min_hold;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_seeded <= 1'b0; r_max_flag <= 1'b0; r_min_flag <= 1'b0;
            r_fast <= '0; r_slow <= '0; r_ref <= '0; r_prev <= '0; r_slope <= '0;
            r_max_hold <= '0; r_min_hold <= '0; r_last <= '0; r_ok <= 1'b0;
            r_neg <= 1'b0; r_x <= '0; r_dref <= '0; r_elapsed <= '0;
        end else begin
            unique case (r_st)
                S_IDLE: begin
                    if (o_cmd_pop) begin
                        r_ok <= i_cmd.ok;
                        r_x  <= i_cmd.sample;
                        if (i_cmd.ack_max) r_max_flag <= 1'b0;
                        if (i_cmd.ack_min) r_min_flag <= 1'b0;
                        if (i_cmd.ok) begin
                            r_seeded <= 1'b1;
                            r_fast <= nf;
                            r_slow <= ns;
                            if (!r_seeded) r_prev <= i_cmd.sample;
                            if (trig) begin
                                r_ref  <= ns;
                                r_last <= i_cmd.now;
                            end else if (!r_seeded) begin
                                r_ref <= i_cmd.sample;
                            end
                            r_dref    <= r_seeded ? r_ref : i_cmd.sample;
                            r_elapsed <= elapsed;
                            r_st      <= div_go ? S_MAG : S_FIN;
                        end else begin
                            r_st <= S_OUT;
                        end
                    end
                end
                S_MAG: begin
                    r_neg <= d[SB];
                    r_st  <= S_DIV;
                end
                S_DIV: begin
                    if (dv_done) begin
                        r_slope <= tfsp_pkg::ema(tfsp_pkg::sat17(raw), r_slope, i_slope_shift);
                        r_st <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (!r_max_flag && r_prev < r_fast && r_fast >= r_x) begin
                        r_max_hold <= r_fast; r_max_flag <= 1'b1;
                    end
                    if (!r_min_flag && r_prev > r_fast && r_fast <= r_x) begin
                        r_min_hold <= r_fast; r_min_flag <= 1'b1;
                    end
                    r_prev <= r_fast;
                    r_st <= S_OUT;
                end
                S_OUT: begin
                    if (!i_stall) r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== hw/rtl/temp_filter_slope_peak.sv =====
// ----------------------------------------------------------------------------
// temp_filter_slope_peak
// temperature sample filter with fast/slow averages, slope and peak latches
//
// channel  direction  handshake
// in       input      i_valid / o_stall
// out      output     o_valid / i_stall
// cfg      input      i_cfg_valid / o_cfg_ready
//
// a rejected word goes S_IDLE, S_OUT in the back end; an accepted one goes
// S_IDLE, S_FIN, S_OUT; one that divides for the slope adds S_MAG (setup)
// and S_DIV (29-step divider); commands pass through a two-entry queue
// synchronous active-low reset sets control and state registers to defaults
// output stall holds the result; input is taken while the queue has room
// ----------------------------------------------------------------------------
module temp_filter_slope_peak (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  tfsp_pkg::t_smp i_sample,
    input  logic        i_sample_present,
    input  logic [tfsp_pkg::TIME_BITS-1:0] i_now_seconds,
    input  logic        i_ack_max,
    input  logic        i_ack_min,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_connected,
    output tfsp_pkg::t_smp o_fast_value,
    output tfsp_pkg::t_smp o_slow_value,
    output tfsp_pkg::t_smp o_slope_value,
    output logic        o_max_found,
    output tfsp_pkg::t_smp o_max_value,
    output logic        o_min_found,
    output tfsp_pkg::t_smp o_min_value,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [tfsp_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    logic [tfsp_pkg::SHIFT_BITS-1:0] r_fast_shift, r_slow_shift, r_slope_shift;
    tfsp_pkg::t_smp r_min_valid, r_max_valid;
    logic [tfsp_pkg::IVAL_BITS-1:0] r_interval;
    logic cmd_valid, cmd_pop;
    tfsp_pkg::t_cmd cmd;
    tfsp_pkg::t_res res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fast_shift <= 4'd1; r_slow_shift <= 4'd4; r_slope_shift <= 4'd3;
            r_min_valid <= -16'sd320; r_max_valid <= 16'sd800; r_interval <= 16'd10;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                tfsp_pkg::CFG_FAST_SHIFT:  r_fast_shift  <= i_cfg_data[3:0];
                tfsp_pkg::CFG_SLOW_SHIFT:  r_slow_shift  <= i_cfg_data[3:0];
                tfsp_pkg::CFG_SLOPE_SHIFT: r_slope_shift <= i_cfg_data[3:0];
                tfsp_pkg::CFG_MIN_VALID:   r_min_valid   <= i_cfg_data;
                tfsp_pkg::CFG_MAX_VALID:   r_max_valid   <= i_cfg_data;
                tfsp_pkg::CFG_INTERVAL:    r_interval    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    tfsp_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_sample(i_sample), .i_present(i_sample_present), .i_now(i_now_seconds),
        .i_ack_max(i_ack_max), .i_ack_min(i_ack_min),
        .i_min_valid(r_min_valid), .i_max_valid(r_max_valid),
        .o_cmd_valid(cmd_valid), .o_cmd(cmd), .i_cmd_pop(cmd_pop)
    );

    tfsp_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd_valid(cmd_valid), .i_cmd(cmd),
        .o_cmd_pop(cmd_pop), .i_fast_shift(r_fast_shift), .i_slow_shift(r_slow_shift),
        .i_slope_shift(r_slope_shift), .i_interval(r_interval),
        .o_valid(o_valid), .i_stall(i_stall), .o_res(res)
    );

    assign o_connected   = res.connected;
    assign o_fast_value  = res.fast_value;
    assign o_slow_value  = res.slow_value;
    assign o_slope_value = res.slope_value;
    assign o_max_found   = res.max_found;
    assign o_max_value   = res.max_value;
    assign o_min_found   = res.min_found;
    assign o_min_value   = res.min_value;
endmodule

// ===== hw/rtl/tfsp_checker.sv =====
// ----------------------------------------------------------------------------
// tfsp_checker
// port-level checks of the temperature filter block
// ----------------------------------------------------------------------------
`include "temp_filter_slope_peak_defines.svh"

module tfsp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic        o_connected,
    input logic        o_max_found,
    input logic [15:0] o_fast_value
);
    `TFSP_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_fast_value))
    `TFSP_ASSERT_NXT(a_one_gap, i_clk, i_rst_n, o_valid && !i_stall, !o_valid)
    `TFSP_ASSERT_NXT(a_flag_hold, i_clk, i_rst_n, o_valid && i_stall, $stable(o_max_found))
    `TFSP_ASSERT_NXT(a_conn_hold, i_clk, i_rst_n, o_valid && i_stall, $stable(o_connected))
    `TFSP_ASSERT_NXT(a_in_hold, i_clk, i_rst_n, i_valid && o_stall, i_valid)
endmodule

bind temp_filter_slope_peak tfsp_checker u_tfsp_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
    .o_valid(o_valid), .i_stall(i_stall), .o_connected(o_connected),
    .o_max_found(o_max_found), .o_fast_value(o_fast_value)
);
